>>> rtl/sitda_pkg.sv
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: shared package
// Widths, character codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int VALUE_W     = 32;
    localparam int NUM_DIGITS  = 10;
    localparam int DIGIT_W     = 4;
    localparam int DIGIT_IDX_W = 4;
    localparam int STEP_CNT_W  = 5;
    localparam int CHAR_W      = 6;
    localparam int OUT_TDATA_W = 8;

    localparam logic [STEP_CNT_W-1:0]  STEP_LAST  = STEP_CNT_W'(VALUE_W - 1);
    localparam logic [DIGIT_IDX_W-1:0] DIGIT_TOP  = DIGIT_IDX_W'(NUM_DIGITS - 1);
    localparam logic [CHAR_W-1:0]      ZERO_CHAR  = 6'd48;
    localparam logic [CHAR_W-1:0]      MINUS_CHAR = 6'd45;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a new value and clear the BCD digits
        logic step;      // one shift-and-adjust step
        logic dec_idx;   // move to the next lower digit
        logic out_load;  // write a character into the output register
        logic out_sign;  // the character written is the minus sign
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic step_done;   // the current step is the final one
        logic digit_zero;  // the selected digit is zero
        logic idx_zero;    // the least significant digit is selected
        logic neg;         // the value being converted is negative
        logic out_free;    // the output register can take a word this cycle
    } t_dp_sts;

endpackage

>>> rtl/sitda_dp.sv
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: datapath
// Magnitude register, shift-and-add-3 BCD converter, digit selection and the
// output register of the character stream.
// ----------------------------------------------------------------------------
module sitda_dp
    import sitda_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic signed [VALUE_W-1:0] i_value,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [CHAR_W-1:0]        o_char,
    output logic                     o_last
);

    logic [VALUE_W-1:0]     r_bin;
    logic [DIGIT_W-1:0]     r_bcd [NUM_DIGITS];
    logic                   r_neg;
    logic [STEP_CNT_W-1:0]  r_cnt;
    logic [DIGIT_IDX_W-1:0] r_idx;
    logic                   r_ovalid;
    logic [CHAR_W-1:0]      r_char;
    logic                   r_last;

    logic [VALUE_W-1:0]     n_mag;
    logic [DIGIT_W-1:0]     n_adj [NUM_DIGITS];
    logic [DIGIT_W-1:0]     n_bcd [NUM_DIGITS];
    logic [DIGIT_W-1:0]     n_digit;

    // Two's complement magnitude; the most negative value maps to 2^31.
    assign n_mag = i_value[VALUE_W-1] ? (~i_value + 1'b1) : i_value;

    // Add three to every digit of five or more, then shift one bit in.
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            n_adj[i] = (r_bcd[i] >= 4'd5) ? (r_bcd[i] + 4'd3) : r_bcd[i];
        end
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (i == 0) begin
                n_bcd[i] = {n_adj[i][DIGIT_W-2:0], r_bin[VALUE_W-1]};
            end else begin
                n_bcd[i] = {n_adj[i][DIGIT_W-2:0], n_adj[i-1][DIGIT_W-1]};
            end
        end
    end

    assign n_digit = r_bcd[r_idx];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin <= n_mag;
            r_neg <= i_value[VALUE_W-1];
            r_cnt <= '0;
            r_idx <= DIGIT_TOP;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_bcd[i] <= '0;
            end
        end else begin
            if (i_cmd.step) begin
                r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    r_bcd[i] <= n_bcd[i];
                end
            end
            if (i_cmd.dec_idx) begin
                r_idx <= r_idx - 1'b1;
            end
        end
    end

    // Output register: valid is control state, the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_sign) begin
                r_char <= MINUS_CHAR;
                r_last <= 1'b0;
            end else begin
                r_char <= ZERO_CHAR + {2'b00, n_digit};
                r_last <= (r_idx == '0);
            end
        end
    end

    assign o_sts.step_done  = (r_cnt == STEP_LAST);
    assign o_sts.digit_zero = (n_digit == '0);
    assign o_sts.idx_zero   = (r_idx == '0);
    assign o_sts.neg        = r_neg;
    assign o_sts.out_free   = !r_ovalid || i_m_tready;

    assign o_m_tvalid = r_ovalid;
    assign o_char     = r_char;
    assign o_last     = r_last;

endmodule

>>> rtl/sitda_ctrl.sv
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: controller
// Sequences the load, the conversion steps, the leading zero skip and the
// emission of the sign and digit characters.
// ----------------------------------------------------------------------------
module sitda_ctrl
    import sitda_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.step = 1'b1;
                if (i_sts.step_done) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (i_sts.digit_zero && !i_sts.idx_zero) begin
                    o_cmd.dec_idx = 1'b1;
                end else if (i_sts.neg) begin
                    n_state = ST_SIGN;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sign = 1'b1;
                    n_state        = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.idx_zero) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.dec_idx = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // A character is never written over one still waiting downstream.
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("character written while output register is occupied");

    // An accepted word always starts a conversion.
    a_accept_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == ST_CONV))
        else $error("accepted word did not start a conversion");

    // The final conversion step hands over to the leading zero skip.
    a_conv_to_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV && i_sts.step_done) |=> (r_state == ST_SKIP))
        else $error("conversion did not end after the final step");

    // Writing the least significant digit ends the number.
    a_last_digit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && o_cmd.out_load && i_sts.idx_zero)
        |=> (r_state == ST_IDLE))
        else $error("controller did not return to idle after the last digit");

    // The index never moves during the conversion steps.
    a_no_dec_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> !o_cmd.dec_idx && !o_cmd.out_load)
        else $error("digit index or output touched during conversion");
`endif

endmodule

>>> rtl/signed_int_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII unit
// Converts one signed 32-bit word into its decimal text, emitted as one ASCII
// character word at a time, most significant character first.
// ----------------------------------------------------------------------------
// Sequence: a load, 32 shift-and-add-3 steps, a skip over leading zero
// digits, any minus sign, then the remaining digits, each character waiting
// while the output register is full. The next number is taken only after
// the last digit of the current one has been written.
// Reset: i_rst_n is synchronous and active low; it returns the controller to
// idle and empties the output register. The datapath payload is not reset.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit
    import sitda_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream: one number per word.
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [VALUE_W-1:0]     i_s_tdata,   // [31:0] value (signed)
    // Output stream: one character per word.
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [5:0] character, [7:6] zero
    output logic                   o_m_tlast    // last_char
);

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic [CHAR_W-1:0] out_char;

    // The controller walks each number through load, conversion, skipping of
    // leading zeros, an optional minus sign and the digits. It only accepts
    // a new word when idle, but the output register lets the last character
    // of one number wait for the sink while the next number is taken in.
    sitda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the magnitude and the ten BCD digits. Zero keeps
    // its least significant digit, so it still gives the single character 0.
    sitda_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_value    (i_s_tdata),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_char     (out_char),
        .o_last     (o_m_tlast)
    );

    // The character fills the low six bits; the word is padded to a byte.
    assign o_m_tdata = {{(OUT_TDATA_W - CHAR_W){1'b0}}, out_char};

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the signed integer to decimal ASCII unit
// Feeds signed 32-bit numbers into the input stream and checks every
// character word on the output stream. The expected text of each number is
// built by a local converter as the number is accepted. Directed corner
// numbers come first, then random numbers of every length and sign, under
// several patterns of source gaps and sink back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    import sitda_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char_word;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [VALUE_W-1:0]     i_s_tdata;   // [31:0] value (signed)
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;   // [5:0] character, [7:6] zero
    logic                   o_m_tlast;   // last_char

    // Numbers waiting to be offered, and the characters still owed by the
    // unit for numbers it has already taken, oldest first.
    logic [VALUE_W-1:0] pending_numbers[$];
    t_char_word         expected_chars[$];

    int  numbers_queued;
    int  numbers_taken;
    int  error_count;
    int  cycle_count;
    int  send_idle_pct;
    int  sink_stall_pct;
    logic number_taken_last_edge;

    signed_int_to_decimal_ascii_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Appends the decimal text of one number to the expected characters:
    // a minus sign for negative numbers, then the digits, most significant
    // first, with the flag on the final digit. The magnitude is taken modulo
    // 2^32, so the most negative number comes out as 2147483648 exactly.
    function automatic void push_decimal_text(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] magnitude;
        logic [3:0]         digits[NUM_DIGITS];
        int                 count;
        t_char_word         word;
        magnitude = value[VALUE_W-1] ? (~value + 1'b1) : value;
        count = 0;
        do begin
            digits[count] = 4'(magnitude % 10);
            magnitude = magnitude / 10;
            count++;
        end while (magnitude != 0 && count < NUM_DIGITS);
        if (value[VALUE_W-1]) begin
            word.code = MINUS_CHAR;
            word.last = 1'b0;
            expected_chars.push_back(word);
        end
        for (int i = count - 1; i >= 0; i--) begin
            word.code = ZERO_CHAR + CHAR_W'(digits[i]);
            word.last = (i == 0);
            expected_chars.push_back(word);
        end
    endfunction

    // Random number: a quarter are raw 32-bit patterns, the rest have a
    // random count of decimal digits, so that short and long texts turn up
    // about equally often.
    function automatic logic [VALUE_W-1:0] random_number();
        longint lo;
        longint hi;
        longint magnitude;
        int     len;
        bit     negative;
        if ($urandom_range(3) == 0) begin
            return $urandom;
        end
        len = $urandom_range(10, 1);
        negative = $urandom_range(1);
        lo = 1;
        for (int i = 1; i < len; i++) lo = lo * 10;
        hi = lo * 10 - 1;
        if (len == 1) lo = 0;
        if (hi > 64'd2147483648) hi = negative ? 64'd2147483648 : 64'd2147483647;
        magnitude = lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1));
        return negative ? VALUE_W'(-magnitude) : VALUE_W'(magnitude);
    endfunction

    task automatic queue_number(input logic [VALUE_W-1:0] value);
        pending_numbers.push_back(value);
        numbers_queued++;
    endtask

    // Blocks until every queued number has been taken and all of its text
    // has come out. Both counts only change at the rising edge.
    task automatic wait_for_drain();
        while (numbers_taken != numbers_queued || expected_chars.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Source side: a new word is offered only once the previous one has been
    // taken or nothing was on offer, so a held word never drops its valid.
    always @(negedge i_clk) begin
        if (!i_s_tvalid || number_taken_last_edge) begin
            if (pending_numbers.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= pending_numbers.pop_front();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: back-pressure is drawn afresh each cycle.
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Both streams are sampled at the rising edge. A number's text is
    // predicted the moment the number is taken; each character word is
    // checked against the oldest outstanding prediction.
    always @(posedge i_clk) begin : monitor
        t_char_word want;
        cycle_count <= cycle_count + 1;
        number_taken_last_edge <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                push_decimal_text(i_s_tdata);
                numbers_taken++;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected word tdata=0x%02h tlast=%b",
                             $time, o_m_tdata, o_m_tlast);
                    error_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (o_m_tdata !== {2'b00, want.code}) begin
                        $display("%0t: character mismatch: expected 0x%02h, got 0x%02h",
                                 $time, {2'b00, want.code}, o_m_tdata);
                        error_count++;
                    end
                    if (o_m_tlast !== want.last) begin
                        $display("%0t: tlast mismatch: expected %b, got %b",
                                 $time, want.last, o_m_tlast);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d numbers taken of %0d",
                     $time, numbers_taken, numbers_queued);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_m_tready     = 1'b0;
        numbers_queued = 0;
        numbers_taken  = 0;
        error_count    = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        number_taken_last_edge = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed numbers: zero, single digits of either sign, the decade
        // boundaries, both ends of the range including the most negative
        // value, and alternating bit patterns.
        queue_number(32'd0);
        queue_number(32'd1);
        queue_number(-32'sd1);
        queue_number(32'd9);
        queue_number(-32'sd9);
        queue_number(32'd10);
        queue_number(-32'sd10);
        queue_number(32'd99);
        queue_number(32'd100);
        queue_number(-32'sd100);
        queue_number(32'd999999999);
        queue_number(32'd1000000000);
        queue_number(-32'sd1000000000);
        queue_number(32'd1999999999);
        queue_number(32'h7FFF_FFFF);
        queue_number(32'h8000_0000);
        queue_number(32'h8000_0001);
        queue_number(32'h5555_5555);
        queue_number(32'hAAAA_AAAA);
        queue_number(32'd1234567890);
        queue_number(-32'sd1234567890);
        queue_number(32'd7);

        // Random phases: no idling, idle source, stalling sink, then both.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 55; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 55; end
                default: begin send_idle_pct = 14; sink_stall_pct = 14; end
            endcase
            repeat (62) queue_number(random_number());
            wait_for_drain();
        end

        // Let any stray words show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_chars.size() != 0) begin
            $display("%0t: %0d characters never arrived", $time, expected_chars.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/sitda_pkg.sv
rtl/sitda_dp.sv
rtl/sitda_ctrl.sv
rtl/signed_int_to_decimal_ascii_unit.sv
verif/tb_top.sv
